FILE: rtl/pcmfpm_pkg.sv
package pcmfpm_pkg;

  // sample_format codes; code 7 is unused and behaves as int32
  typedef enum logic [2:0] {
    FMT_INT16        = 3'd0,
    FMT_INT16_IN32   = 3'd1,
    FMT_INT18_IN32   = 3'd2,
    FMT_INT20_IN32   = 3'd3,
    FMT_INT24_IN32   = 3'd4,
    FMT_INT24_PACKED = 3'd5,
    FMT_INT32        = 3'd6
  } fmt_e;

  // positive full-scale codes per container
  localparam logic [31:0] MAX_INT16 = 32'd32767;
  localparam logic [31:0] MAX_INT18 = 32'd131071;
  localparam logic [31:0] MAX_INT20 = 32'd524287;
  localparam logic [31:0] MAX_INT24 = 32'd8388607;
  localparam logic [31:0] MAX_INT32 = 32'd2147483647;
  // negative 16-bit samples scale by 2^15
  localparam logic [31:0] NEG_INT16_MUL = 32'd32768;

  localparam logic signed [63:0] SMP_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SMP_MIN = -64'sd2147483648;

  // converter result handed to the output stage
  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] sample;
    logic [31:0] mag;
  } conv_t;

endpackage

FILE: rtl/pcmfpm_convert.sv
module pcmfpm_convert #(
  parameter int FRAC_BITS = 27
) (
  input  logic [2:0]         fmt_i,
  input  logic               rec_i,
  input  logic signed [31:0] sample_i,
  input  logic [31:0]        raw_i,
  output pcmfpm_pkg::conv_t  res_o
);
  import pcmfpm_pkg::*;

  localparam logic signed [63:0] One  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);
  // 2^15 = 1 mod 32767, so 2^F = 32767*Q15 + 2^R15
  localparam int R15 = FRAC_BITS % 15;
  localparam logic [63:0] Q15Full =
    ((64'd1 << FRAC_BITS) - (64'd1 << R15)) / 64'd32767;
  localparam logic [16:0] Q15 = Q15Full[16:0];

  // round(v * 2^F / 2^k), halves up; k is always a constant
  function automatic logic signed [63:0] scale_pow2(input logic signed [63:0] v,
                                                    input int k);
    int sl;
    int sr;
    logic signed [63:0] rnd;
    sl  = (FRAC_BITS >= k) ? FRAC_BITS - k : 0;
    sr  = (FRAC_BITS >= k) ? 0 : k - FRAC_BITS;
    rnd = (sr > 0) ? (64'sd1 <<< (sr - 1)) : 64'sd0;
    return ((v <<< sl) + rnd) >>> sr;
  endfunction

  logic               fmt16;
  logic signed [63:0] x64;
  logic [31:0]        pb_max;
  logic [31:0]        pb_mul;
  logic signed [63:0] pb_max64;
  logic signed [63:0] pb_code;
  logic [31:0]        pb_raw;

  logic signed [15:0] v16;
  logic signed [63:0] v16_64;
  logic signed [63:0] v24_64;
  logic signed [63:0] v32_64;
  logic [29:0]        bsum;
  logic [15:0]        bfold;
  logic [1:0]         bcorr;
  logic signed [63:0] rec_val;
  logic signed [31:0] rec_sat;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] prod64;

  assign fmt16  = (fmt_i == FMT_INT16) || (fmt_i == FMT_INT16_IN32);
  assign x64    = 64'(sample_i);
  assign v16    = raw_i[15:0];
  assign v16_64 = 64'(v16);
  assign v24_64 = 64'($signed(raw_i[23:0]));
  assign v32_64 = 64'($signed(raw_i));

  always_comb begin
    case (fmt_i)
      FMT_INT16, FMT_INT16_IN32:        pb_max = MAX_INT16;
      FMT_INT18_IN32:                   pb_max = MAX_INT18;
      FMT_INT20_IN32:                   pb_max = MAX_INT20;
      FMT_INT24_IN32, FMT_INT24_PACKED: pb_max = MAX_INT24;
      default:                          pb_max = MAX_INT32;
    endcase
  end

  assign pb_mul   = (fmt16 && (sample_i <= 32'sd0)) ? NEG_INT16_MUL : pb_max;
  assign pb_max64 = $signed({32'd0, pb_max});

  // positive 16-bit record: split the divide by 32767 into Q15 multiply + fold
  assign bsum  = (30'(v16[14:0]) << R15) + 30'd16383;
  assign bfold = {1'b0, bsum[29:15]} + {1'b0, bsum[14:0]};
  assign bcorr = (bfold >= 16'd65534) ? 2'd2 : ((bfold >= 16'd32767) ? 2'd1 : 2'd0);

  // one multiplier shared by both directions
  assign mul_a  = rec_i ? $signed({18'd0, v16[14:0]}) : $signed({sample_i[31], sample_i});
  assign mul_b  = rec_i ? $signed({16'd0, Q15}) : $signed({1'b0, pb_mul});
  assign prod   = mul_a * mul_b;
  assign prod64 = prod[63:0];

  always_comb begin
    if (x64 >= One) begin
      pb_code = pb_max64;
    end else if (x64 <= -One) begin
      pb_code = -pb_max64 - 64'sd1;
    end else begin
      pb_code = (prod64 + Half) >>> FRAC_BITS;
    end
    if (fmt16) begin
      pb_raw = {16'd0, pb_code[15:0]};
    end else if (fmt_i == FMT_INT24_PACKED) begin
      pb_raw = {8'd0, pb_code[23:0]};
    end else begin
      pb_raw = pb_code[31:0];
    end
  end

  always_comb begin
    case (fmt_i)
      FMT_INT16, FMT_INT16_IN32: begin
        if (v16 > 16'sd0) begin
          rec_val = prod64 + $signed({49'd0, bsum[29:15]}) + $signed({62'd0, bcorr});
        end else begin
          rec_val = scale_pow2(v16_64, 15);
        end
      end
      FMT_INT18_IN32:                   rec_val = scale_pow2(v32_64, 17);
      FMT_INT20_IN32:                   rec_val = scale_pow2(v32_64, 19);
      FMT_INT24_IN32, FMT_INT24_PACKED: rec_val = scale_pow2(v24_64, 23);
      default:                          rec_val = scale_pow2(v32_64, 31);
    endcase
    if (rec_val > SMP_MAX) begin
      rec_sat = 32'sh7FFFFFFF;
    end else if (rec_val < SMP_MIN) begin
      rec_sat = 32'sh80000000;
    end else begin
      rec_sat = rec_val[31:0];
    end
  end

  always_comb begin
    if (rec_i) begin
      res_o.raw    = 32'd0;
      res_o.sample = rec_sat;
      res_o.mag    = rec_sat[31] ? 32'(-rec_sat) : rec_sat;
    end else begin
      res_o.raw    = pb_raw;
      res_o.sample = 32'd0;
      res_o.mag    = sample_i[31] ? 32'(-x64) : sample_i;
    end
  end

endmodule

FILE: rtl/pcm_format_converter_peak_meter.sv
// The accepting edge loads an input item into the input register; the result
//   register loads from the input register when it is empty or its item is taken.
// Throughput: one item per cycle unless the output stalls; the converter is a
//   single combinational pass with one shared multiplier between the two registers.
// Reset (rst_ni low, asynchronous): pipeline empty, sample_format int16,
//   running and held peaks zero.
module pcm_format_converter_peak_meter #(
  parameter int FRAC_BITS = 27
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: sample_format
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_wdata_i,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // [31:0] sample_in, [63:32] raw_word
  input  logic         s_axis_tuser,  // req_type
  input  logic         s_axis_tlast,  // last_in
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // [31:0] raw_out, [63:32] sample_out,
                                      // [95:64] block_peak, [127:96] peak_hold
  output logic         m_axis_tlast   // last_out
);
  import pcmfpm_pkg::*;

  // config register
  logic [2:0]  fmt_q;

  // input register stage
  logic        v1_q;
  logic        rec1_q;
  logic [31:0] smp1_q;
  logic [31:0] raw1_q;
  logic        last1_q;

  // result register stage
  logic        v2_q;
  logic [31:0] raw2_q;
  logic [31:0] smp2_q;
  logic [31:0] blk2_q;
  logic        last2_q;

  // meter state
  logic [31:0] run_q, run_d;
  logic [31:0] held_q, held_d;
  logic [31:0] blk_d;
  logic [31:0] run_max;

  logic        adv2;
  logic        in_acc;
  conv_t       conv;

  // result register frees when empty or taken; input stage moves with it
  assign adv2          = !v2_q || m_axis_tready;
  assign s_axis_tready = !v1_q || adv2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  pcmfpm_convert #(
    .FRAC_BITS(FRAC_BITS)
  ) u_convert (
    .fmt_i    (fmt_q),
    .rec_i    (rec1_q),
    .sample_i (smp1_q),
    .raw_i    (raw1_q),
    .res_o    (conv)
  );

  // meter: fold magnitude in; on buffer end report, update hold, clear
  always_comb begin
    run_max = (conv.mag > run_q) ? conv.mag : run_q;
    run_d   = run_max;
    held_d  = held_q;
    blk_d   = 32'd0;
    if (last1_q) begin
      blk_d  = run_max;
      held_d = (run_max > held_q) ? run_max : held_q;
      run_d  = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_INT16;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      run_q  <= 32'd0;
      held_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          run_q  <= run_d;
          held_q <= held_d;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec1_q  <= s_axis_tuser;
      smp1_q  <= s_axis_tdata[31:0];
      raw1_q  <= s_axis_tdata[63:32];
      last1_q <= s_axis_tlast;
    end
    if (adv2 && v1_q) begin
      raw2_q  <= conv.raw;
      smp2_q  <= conv.sample;
      blk2_q  <= blk_d;
      last2_q <= last1_q;
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {held_q, blk2_q, smp2_q, raw2_q};
  assign m_axis_tlast  = last2_q;

`ifndef ASSERT_OFF
  // peak hold only grows
  a_hold_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q >= $past(held_q))
    else $error("peak hold decreased");

  // block peak is zero except on a buffer end
  a_blk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[95:64] == 32'd0))
    else $error("block peak nonzero without last");

  // a reported block peak never exceeds the hold shown with it
  a_blk_le_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[95:64] <= m_axis_tdata[127:96]))
    else $error("block peak above peak hold");

  // a held input item blocks new input
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while pipeline full");
`endif

endmodule

FILE: dv/pcm_format_converter_peak_meter_tb.sv
`timescale 1ns / 100ps

module pcm_format_converter_peak_meter_tb;
  import pcmfpm_pkg::*;

  localparam int FRAC_BITS = 27;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  // cycles from input accept to the earliest result accept
  localparam int PIPE_LAT = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_ROWS = 25;
  localparam int PHASES = 3;
  localparam int SEGS = 6;
  localparam int SEG_ITEMS = 88;

  // request kinds carried on tuser
  localparam bit REQ_PLAY = 1'b0;
  localparam bit REQ_REC  = 1'b1;
  // format code without a name in the package; must act as int32
  localparam logic [2:0] FMT_UNUSED = 3'd7;
  localparam logic [31:0] HOLD_FS = 32'h8000_0000;

  // one result item, fields in the order of m_axis_tdata from the lsb up
  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] smp;
    logic [31:0] blk;
    logic [31:0] hold;
    logic        last;
  } pcm_result_t;

  // directed row: format to run under, input item, and a typed-in result
  // where it can be read off directly (otherwise the predictor decides)
  typedef struct {
    logic [2:0]  fmt;
    bit          req;
    logic [31:0] smp;
    logic [31:0] word;
    bit          last;
    bit          typed;
    pcm_result_t res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_wdata_i = 3'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [31:0] sample_in, [63:32] raw_word
  logic         s_axis_tuser = 1'b0; // req_type
  logic         s_axis_tlast = 1'b0; // last_in
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // raw_out, sample_out, block_peak, peak_hold
  logic         m_axis_tlast;        // last_out

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // predictor state: format register and the two peak registers
  logic [2:0]  fmt_q = 3'd0;
  logic [31:0] running_pk = '0;
  logic [31:0] held_pk = '0;

  pcm_result_t due_results[$];
  pcm_result_t head_r;
  int mismatch_cnt = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int idle_cnt;

  int src_pct[PHASES] = '{29, 52, 0};
  int snk_pct[PHASES] = '{52, 29, 0};

  // Directed items. The peak hold saturates at full scale on the fourth item
  // and stays there for the rest of the run.
  dir_row_t dir_rows[DIR_ROWS] = '{
    // int16: clip at +/- one, then the two 32-bit extremes
    '{FMT_INT16, REQ_PLAY, 32'h0800_0000, 32'h0, 1'b0, 1'b1,
      '{32'h0000_7FFF, 32'h0, 32'h0, 32'h0, 1'b0}},
    '{FMT_INT16, REQ_PLAY, 32'hF800_0000, 32'h0, 1'b1, 1'b1,
      '{32'h0000_8000, 32'h0, 32'h0800_0000, 32'h0800_0000, 1'b1}},
    '{FMT_INT16, REQ_PLAY, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1,
      '{32'h0000_7FFF, 32'h0, 32'h0, 32'h0800_0000, 1'b0}},
    '{FMT_INT16, REQ_PLAY, 32'h8000_0000, 32'h0, 1'b1, 1'b1,
      '{32'h0000_8000, 32'h0, HOLD_FS, HOLD_FS, 1'b1}},
    '{FMT_INT16, REQ_PLAY, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{32'h0, 32'h0, 32'h0, HOLD_FS, 1'b0}},
    // negative half steps of the 2^15 scale, then +0.5 rounding upward
    '{FMT_INT16, REQ_PLAY, 32'hFFFF_F800, 32'h0, 1'b0, 1'b0, '0},
    '{FMT_INT16, REQ_PLAY, 32'hFFFF_E800, 32'h0, 1'b0, 1'b0, '0},
    '{FMT_INT16, REQ_PLAY, 32'h0400_0000, 32'h0, 1'b1, 1'b0, '0},
    // record: positive full scale over 32767, negative over 32768
    '{FMT_INT16, REQ_REC, 32'hDEAD_BEEF, 32'h0000_7FFF, 1'b0, 1'b1,
      '{32'h0, 32'h0800_0000, 32'h0, HOLD_FS, 1'b0}},
    '{FMT_INT16, REQ_REC, 32'h0, 32'hFFFF_8000, 1'b1, 1'b1,
      '{32'h0, 32'hF800_0000, 32'h0800_0000, HOLD_FS, 1'b1}},
    // int16 in 32: upper half of the word must not matter
    '{FMT_INT16_IN32, REQ_REC, 32'h0, 32'hABCD_0001, 1'b0, 1'b0, '0},
    '{FMT_INT16_IN32, REQ_PLAY, 32'h0000_1000, 32'h0, 1'b1, 1'b0, '0},
    // int18: record saturates both ways
    '{FMT_INT18_IN32, REQ_PLAY, 32'h0800_0000, 32'h0, 1'b0, 1'b1,
      '{32'h0001_FFFF, 32'h0, 32'h0, HOLD_FS, 1'b0}},
    '{FMT_INT18_IN32, REQ_REC, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1,
      '{32'h0, 32'h7FFF_FFFF, 32'h0, HOLD_FS, 1'b0}},
    '{FMT_INT18_IN32, REQ_REC, 32'h0, 32'h8000_0000, 1'b1, 1'b1,
      '{32'h0, 32'h8000_0000, HOLD_FS, HOLD_FS, 1'b1}},
    '{FMT_INT20_IN32, REQ_PLAY, 32'hF800_0000, 32'h0, 1'b0, 1'b1,
      '{32'hFFF8_0000, 32'h0, 32'h0, HOLD_FS, 1'b0}},
    '{FMT_INT20_IN32, REQ_REC, 32'h0, 32'h0000_0001, 1'b0, 1'b0, '0},
    '{FMT_INT24_IN32, REQ_PLAY, 32'h07FF_FFFF, 32'h0, 1'b0, 1'b0, '0},
    '{FMT_INT24_IN32, REQ_REC, 32'h0, 32'h1280_0000, 1'b0, 1'b0, '0},
    // packed int24 keeps only the low three bytes
    '{FMT_INT24_PACKED, REQ_PLAY, 32'hF800_0000, 32'h0, 1'b0, 1'b1,
      '{32'h0080_0000, 32'h0, 32'h0, HOLD_FS, 1'b0}},
    '{FMT_INT24_PACKED, REQ_REC, 32'h0, 32'hFF7F_FFFF, 1'b1, 1'b0, '0},
    '{FMT_INT32, REQ_PLAY, 32'hF800_0000, 32'h0, 1'b0, 1'b1,
      '{32'h8000_0000, 32'h0, 32'h0, HOLD_FS, 1'b0}},
    // int32 record: -0.5 LSB rounds to zero, +0.5 rounds up
    '{FMT_INT32, REQ_REC, 32'h0, 32'hFFFF_FFF8, 1'b0, 1'b0, '0},
    '{FMT_INT32, REQ_REC, 32'h0, 32'h0000_0008, 1'b1, 1'b0, '0},
    // unused code 7 acts as int32
    '{FMT_UNUSED, REQ_PLAY, 32'h0800_0000, 32'h0, 1'b1, 1'b1,
      '{32'h7FFF_FFFF, 32'h0, 32'h0800_0000, HOLD_FS, 1'b1}}
  };

  pcm_format_converter_peak_meter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor division, den > 0
  function automatic longint div_floor(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // Converts one item under the current format and updates the peak
  // registers; returns the result item it should produce.
  function automatic pcm_result_t convert_and_meter(bit req, logic [31:0] smp_in,
                                                    logic [31:0] word, bit last);
    pcm_result_t r;
    longint x, code, m, v, den, rec, mag;
    logic [31:0] mask;
    r = '0;
    if (req == REQ_PLAY) begin
      x = longint'($signed(smp_in));
      mask = 32'hFFFF_FFFF;
      case (fmt_q)
        FMT_INT16, FMT_INT16_IN32: begin
          // positive side scales by 32767, zero and below by 32768
          mask = 32'h0000_FFFF;
          if (x > 0)
            code = (x >= ONE) ? longint'(MAX_INT16)
                              : div_floor(2 * x * longint'(MAX_INT16) + ONE, 2 * ONE);
          else
            code = (x <= -ONE) ? -longint'(NEG_INT16_MUL)
                               : div_floor(2 * x * longint'(NEG_INT16_MUL) + ONE, 2 * ONE);
        end
        default: begin
          case (fmt_q)
            FMT_INT18_IN32:   m = longint'(MAX_INT18);
            FMT_INT20_IN32:   m = longint'(MAX_INT20);
            FMT_INT24_IN32:   m = longint'(MAX_INT24);
            FMT_INT24_PACKED: begin
              m = longint'(MAX_INT24);
              mask = 32'h00FF_FFFF;
            end
            default:          m = longint'(MAX_INT32);
          endcase
          if (x >= ONE)       code = m;
          else if (x <= -ONE) code = -m - 1;
          else                code = div_floor(2 * x * m + ONE, 2 * ONE);
        end
      endcase
      r.raw = code[31:0] & mask;
      mag = (x < 0) ? -x : x;
    end else begin
      case (fmt_q)
        FMT_INT16, FMT_INT16_IN32: begin
          v = longint'($signed(word[15:0]));
          den = (v > 0) ? longint'(MAX_INT16) : longint'(NEG_INT16_MUL);
        end
        FMT_INT18_IN32: begin
          v = longint'($signed(word));
          den = longint'(1) << 17;
        end
        FMT_INT20_IN32: begin
          v = longint'($signed(word));
          den = longint'(1) << 19;
        end
        FMT_INT24_IN32, FMT_INT24_PACKED: begin
          v = longint'($signed(word[23:0]));
          den = longint'(1) << 23;
        end
        default: begin
          v = longint'($signed(word));
          den = longint'(1) << 31;
        end
      endcase
      rec = div_floor(2 * v * ONE + den, 2 * den);
      if (rec > SMP_MAX) rec = SMP_MAX;
      if (rec < SMP_MIN) rec = SMP_MIN;
      r.smp = rec[31:0];
      mag = (rec < 0) ? -rec : rec;
    end
    if (mag > longint'(running_pk)) running_pk = mag[31:0];
    if (last) begin
      r.blk = running_pk;
      if (running_pk > held_pk) held_pk = running_pk;
      running_pk = '0;
    end
    r.hold = held_pk;
    r.last = last;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Offers one item, with random sender gaps, and queues its result once
  // the item is taken. tvalid stays up into the next call.
  task automatic send_item(bit req, logic [31:0] smp, logic [31:0] word, bit last,
                           bit typed, pcm_result_t typed_res);
    pcm_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {word, smp};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = convert_and_meter(req, smp, word, last);
    due_results.push_back(typed ? typed_res : predicted);
  endtask

  // Format writes only with the pipe empty.
  task automatic set_format(logic [2:0] f);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fmt_q = f;
  endtask

  // receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

  // result checker: every taken result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_acc) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected item raw_out", m_axis_tdata[31:0], '0);
      end else begin
        head_r = due_results.pop_front();
        if (m_axis_tdata[31:0] !== head_r.raw)
          flag_mismatch("raw_out", m_axis_tdata[31:0], head_r.raw);
        if (m_axis_tdata[63:32] !== head_r.smp)
          flag_mismatch("sample_out", m_axis_tdata[63:32], head_r.smp);
        if (m_axis_tdata[95:64] !== head_r.blk)
          flag_mismatch("block_peak", m_axis_tdata[95:64], head_r.blk);
        if (m_axis_tdata[127:96] !== head_r.hold)
          flag_mismatch("peak_hold", m_axis_tdata[127:96], head_r.hold);
        if (m_axis_tlast !== head_r.last)
          flag_mismatch("last_out", {31'b0, m_axis_tlast}, {31'b0, head_r.last});
      end
    end
  end

  // watchdog: too long without an input item being taken
  initial begin
    idle_cnt = 0;
    while (idle_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_acc) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("[pcm_format_converter_peak_meter] ERROR");
    $finish;
  end

  initial begin
    int items, len;
    bit req;
    logic [31:0] smp, word, rnd;
    logic [2:0] f;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = src_pct[0];
    snk_idle_pct = snk_pct[0];

    // directed part; the first row also writes the reset format explicitly
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || dir_rows[i].fmt != fmt_q) set_format(dir_rows[i].fmt);
      send_item(dir_rows[i].req, dir_rows[i].smp, dir_rows[i].word, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].res);
    end

    // random part: per idling phase, a few format segments, each made of
    // buffers of random length closed by last
    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct = src_pct[p];
      snk_idle_pct = snk_pct[p];
      for (int seg = 0; seg < SEGS; seg++) begin
        rnd = $urandom_range(0, 7);
        f = (seg == 0) ? FMT_INT16 : (seg == SEGS - 1) ? FMT_UNUSED : rnd[2:0];
        set_format(f);
        items = 0;
        while (items < SEG_ITEMS) begin
          len = $urandom_range(1, 24);
          for (int k = 0; k < len; k++) begin
            req = $urandom_range(0, 1);
            rnd = $urandom;
            case ($urandom_range(0, 9))
              0, 1:       smp = $urandom;
              2, 3, 4, 5: smp = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
              6:          smp = (rnd[0] ? 32'h0800_0000 : 32'hF800_0000)
                                + $urandom_range(0, 4) - 2;
              7:          smp = $urandom_range(0, 8191) - 4096;
              8: begin
                case ($urandom_range(0, 4))
                  0:       smp = 32'h7FFF_FFFF;
                  1:       smp = 32'h8000_0000;
                  2:       smp = 32'h0400_0000;
                  3:       smp = 32'hFC00_0000;
                  default: smp = 32'h0;
                endcase
              end
              // multiples of 2^11 hit the rounding ties of the 16-bit scale
              default:    smp = rnd[1] ? (rnd & 32'h07FF_F800)
                                       : -(rnd & 32'h07FF_F800);
            endcase
            rnd = $urandom;
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: word = $urandom;
              5, 6:          word = $urandom_range(0, 64) - 32;
              7: begin
                case ($urandom_range(0, 3))
                  0:       word = {rnd[31:16], 16'h7FFF};
                  1:       word = {rnd[31:16], 16'h8000};
                  2:       word = {rnd[31:16], 16'h0001};
                  default: word = {rnd[31:16], 16'hFFFF};
                endcase
              end
              8:             word = {rnd[31:24], rnd[0] ? 24'h7F_FFFF : 24'h80_0000};
              default: begin
                case ($urandom_range(0, 2))
                  0:       word = 32'h7FFF_FFFF;
                  1:       word = 32'h8000_0000;
                  default: word = 32'h0;
                endcase
              end
            endcase
            send_item(req, smp, word, k == len - 1, 1'b0, '0);
            items++;
          end
        end
      end
    end

    // drain, then give stray results a chance to show up
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (2 * PIPE_LAT + 2) @(negedge clk_i);

    if (mismatch_cnt == 0)
      $display("[pcm_format_converter_peak_meter] OK");
    else
      $display("[pcm_format_converter_peak_meter] ERROR");
    $finish;
  end

endmodule
